/* rtl/slcgb_pkg.sv */
// Shared types, constants and reply text for the serial line command bridge.
`default_nettype none

package slcgb_pkg;

   localparam int LINE_MAX_DEFAULT = 100;
   localparam int QUEUE_DEPTH      = 2;
   localparam int IDX_W            = 5;

   localparam logic [7:0] CHAR_LF   = 8'h0a;
   localparam logic [7:0] CHAR_CR   = 8'h0d;
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_R    = 8'h72;
   localparam logic [7:0] CHAR_D    = 8'h64;
   localparam logic [7:0] CHAR_S    = 8'h73;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;

   typedef enum logic [2:0] {
      REPLY_RESET,
      REPLY_SET,
      REPLY_BAD,
      REPLY_UNKNOWN,
      REPLY_SENSE
   } reply_type;

   typedef struct packed {
      reply_type  kind;
      logic [1:0] levels;
      logic [1:0] sense;
   } entry_type;

   localparam int LEN_RESET   = 14;
   localparam int LEN_SET     = 11;
   localparam int LEN_BAD     = 19;
   localparam int LEN_UNKNOWN = 16;
   localparam int LEN_SENSE   = 2;

   localparam logic [8*LEN_RESET-1:0]   TXT_RESET   = "Outputs Reset\n";
   localparam logic [8*LEN_SET-1:0]     TXT_SET     = "Output Set\n";
   localparam logic [8*LEN_BAD-1:0]     TXT_BAD     = "Invalid sXY Format\n";
   localparam logic [8*LEN_UNKNOWN-1:0] TXT_UNKNOWN = "Unknown Command\n";

   function automatic logic [IDX_W-1:0] reply_len(reply_type kind);
      logic [IDX_W-1:0] len;
      case (kind)
         REPLY_RESET:   len = IDX_W'(LEN_RESET);
         REPLY_SET:     len = IDX_W'(LEN_SET);
         REPLY_BAD:     len = IDX_W'(LEN_BAD);
         REPLY_UNKNOWN: len = IDX_W'(LEN_UNKNOWN);
         REPLY_SENSE:   len = IDX_W'(LEN_SENSE);
         default:       len = IDX_W'(LEN_UNKNOWN);
      endcase
      return len;
   endfunction

   // first character of a string sits in its top byte
   function automatic logic [7:0] reply_char(reply_type kind, logic [IDX_W-1:0] idx,
                                             logic [1:0] sense);
      logic [7:0] c;
      int         i;
      i = int'(idx);
      c = CHAR_LF;
      case (kind)
         REPLY_RESET:   if (i < LEN_RESET)   c = TXT_RESET[8*(LEN_RESET-1-i) +: 8];
         REPLY_SET:     if (i < LEN_SET)     c = TXT_SET[8*(LEN_SET-1-i) +: 8];
         REPLY_BAD:     if (i < LEN_BAD)     c = TXT_BAD[8*(LEN_BAD-1-i) +: 8];
         REPLY_UNKNOWN: if (i < LEN_UNKNOWN) c = TXT_UNKNOWN[8*(LEN_UNKNOWN-1-i) +: 8];
         REPLY_SENSE:   if (i == 0)          c = CHAR_ZERO | {6'd0, sense};
         default:       c = CHAR_LF;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/serial_line_command_gpio_bridge.sv */
// A terminator request's reply is written into the reply queue; its first byte is then
// registered into the output register when the sender is idle.
// The front end takes one request per cycle unless stalled; reply bytes leave one per cycle
// from the output register while rsp_stall is low, and a reply is 2 to 19 bytes long.
// The front end stalls only while the two-entry reply queue is full.
// Reset (synchronous): clears the line state, the front end's pin levels, the queue and rsp_valid.
`default_nettype none

module serial_line_command_gpio_bridge #(
   parameter int LINE_MAX = slcgb_pkg::LINE_MAX_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_sensor_one,
   input  wire logic       req_sensor_two,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_reply_last,
   output logic            rsp_drive_zero,
   output logic            rsp_drive_one
);

   logic                 push, pop, full, empty;
   slcgb_pkg::entry_type push_entry, head_entry;

   slcgb_front #(.LINE_MAX(LINE_MAX)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_sensor_one (req_sensor_one),
      .req_sensor_two (req_sensor_two),
      .queue_full     (full),
      .push           (push),
      .push_entry     (push_entry)
   );

   slcgb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head_entry (head_entry)
   );

   slcgb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (empty),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_reply_last (rsp_reply_last),
      .rsp_drive_zero (rsp_drive_zero),
      .rsp_drive_one  (rsp_drive_one)
   );

endmodule

`default_nettype wire

/* rtl/slcgb_front.sv */
// Front end: collects the command line and classifies it on a terminator.
`default_nettype none

module slcgb_front #(
   parameter int LINE_MAX = slcgb_pkg::LINE_MAX_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_rx_byte,
   input  wire logic                 req_sensor_one,
   input  wire logic                 req_sensor_two,
   input  wire logic                 queue_full,
   output logic                      push,
   output slcgb_pkg::entry_type      push_entry
);

   localparam int CNT_W = $clog2(LINE_MAX);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_MAX - 1);

   logic [CNT_W-1:0] line_count_ff, line_count_in;
   logic [2:0]       text_len_ff, text_len_in;   // saturates at 4
   logic             zero_seen_ff, zero_seen_in;
   logic [1:0]       levels_ff, levels_in;
   logic [7:0]       head_ff [3];

   logic accept, is_term, head_we;
   logic cmd_r, cmd_d, cmd_s, xy_ok;
   logic [1:0] pin_mask;
   slcgb_pkg::reply_type kind;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_term   = (req_rx_byte == slcgb_pkg::CHAR_LF) || (req_rx_byte == slcgb_pkg::CHAR_CR);
   assign push      = accept && is_term;

   assign cmd_r = (text_len_ff == 3'd1) && (head_ff[0] == slcgb_pkg::CHAR_R);
   assign cmd_d = (text_len_ff == 3'd1) && (head_ff[0] == slcgb_pkg::CHAR_D);
   assign cmd_s = (text_len_ff == 3'd3) && (head_ff[0] == slcgb_pkg::CHAR_S);
   assign xy_ok = ((head_ff[1] == slcgb_pkg::CHAR_ZERO) || (head_ff[1] == slcgb_pkg::CHAR_ONE))
               && ((head_ff[2] == slcgb_pkg::CHAR_ZERO) || (head_ff[2] == slcgb_pkg::CHAR_ONE));
   assign pin_mask = (head_ff[1] == slcgb_pkg::CHAR_ONE) ? 2'b10 : 2'b01;

   always_comb begin
      kind      = slcgb_pkg::REPLY_UNKNOWN;
      levels_in = levels_ff;
      if (cmd_r) begin
         kind      = slcgb_pkg::REPLY_RESET;
         levels_in = 2'b00;
      end else if (cmd_d) begin
         kind = slcgb_pkg::REPLY_SENSE;
      end else if (cmd_s) begin
         if (xy_ok) begin
            kind = slcgb_pkg::REPLY_SET;
            if (head_ff[2] == slcgb_pkg::CHAR_ONE) levels_in = levels_ff | pin_mask;
            else levels_in = levels_ff & ~pin_mask;
         end else begin
            kind = slcgb_pkg::REPLY_BAD;
         end
      end
      if (!push) levels_in = levels_ff;
   end

   assign push_entry.kind   = kind;
   assign push_entry.levels = levels_in;
   assign push_entry.sense  = {req_sensor_one, req_sensor_two};

   always_comb begin
      line_count_in = line_count_ff;
      text_len_in   = text_len_ff;
      zero_seen_in  = zero_seen_ff;
      head_we       = 1'b0;
      if (accept) begin
         if (is_term || (line_count_ff >= CNT_LIMIT)) begin
            // terminator or overlong line: start over
            line_count_in = '0;
            text_len_in   = 3'd0;
            zero_seen_in  = 1'b0;
         end else begin
            line_count_in = line_count_ff + 1'b1;
            if (req_rx_byte == slcgb_pkg::CHAR_NUL) begin
               zero_seen_in = 1'b1;
            end else if (!zero_seen_ff) begin
               head_we     = (text_len_ff < 3'd3);
               text_len_in = (text_len_ff == 3'd4) ? 3'd4 : text_len_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
         text_len_ff   <= 3'd0;
         zero_seen_ff  <= 1'b0;
         levels_ff     <= 2'b00;
      end else begin
         line_count_ff <= line_count_in;
         text_len_ff   <= text_len_in;
         zero_seen_ff  <= zero_seen_in;
         levels_ff     <= levels_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) head_ff[text_len_ff[1:0]] <= req_rx_byte;
   end

endmodule

`default_nettype wire

/* rtl/slcgb_queue.sv */
// Short reply queue between front end and reply sender.
`default_nettype none

module slcgb_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire slcgb_pkg::entry_type push_entry,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      empty,
   output slcgb_pkg::entry_type      head_entry
);

   localparam int DEPTH = slcgb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   slcgb_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign empty      = (count_ff == '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("reply queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("reply queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("reply queue count out of range");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !empty)
      else $error("reply queue empty after a write");

endmodule

`default_nettype wire

/* rtl/slcgb_back.sv */
// Reply sender: spells out queued replies one byte per cycle into the output register while it is not stalled.
`default_nettype none

module slcgb_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 queue_empty,
   input  wire slcgb_pkg::entry_type head_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_reply_last,
   output logic                      rsp_drive_zero,
   output logic                      rsp_drive_one
);

   localparam int IDX_W = slcgb_pkg::IDX_W;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff;
   logic             last_ff;
   logic [1:0]       levels_ff;
   logic             load, last;

   assign load = !queue_empty && (!valid_ff || !rsp_stall);
   assign last = (idx_ff == slcgb_pkg::reply_len(head_entry.kind) - 1'b1);
   assign pop  = load && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         idx_in   = last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= slcgb_pkg::reply_char(head_entry.kind, idx_ff, head_entry.sense);
         last_ff   <= last;
         levels_ff <= head_entry.levels;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_tx_byte    = byte_ff;
   assign rsp_reply_last = last_ff;
   assign rsp_drive_zero = levels_ff[0];
   assign rsp_drive_one  = levels_ff[1];

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Testbench for the serial line command bridge: directed and random command traffic.
module tb_top;

   localparam int LINE_LIMIT   = slcgb_pkg::LINE_MAX_DEFAULT;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 210;
   localparam int TAIL_CYCLES  = 20;

   typedef struct {
      logic [7:0] tx_byte;
      logic       last;
      logic       pin_zero;
      logic       pin_one;
   } reply_byte_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte    = 8'h00;
   logic       req_sensor_one = 1'b0;
   logic       req_sensor_two = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_reply_last;
   logic       rsp_drive_zero;
   logic       rsp_drive_one;

   reply_byte_type replies_due[$];
   int             failures      = 0;
   int             requests_sent = 0;
   int             quiet_cycles  = 0;
   bit             calm          = 1'b0;

   // predicted line state
   int unsigned line_len   = 0;
   int unsigned text_len   = 0;
   logic [7:0]  head[3]    = '{8'h00, 8'h00, 8'h00};
   bit          nul_seen   = 1'b0;
   logic [1:0]  pin_levels = 2'b00;

   serial_line_command_gpio_bridge u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_sensor_one (req_sensor_one),
      .req_sensor_two (req_sensor_two),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_reply_last (rsp_reply_last),
      .rsp_drive_zero (rsp_drive_zero),
      .rsp_drive_one  (rsp_drive_one)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic void push_reply_byte(logic [7:0] c, logic last);
      reply_byte_type r;
      r.tx_byte  = c;
      r.last     = last;
      r.pin_zero = pin_levels[0];
      r.pin_one  = pin_levels[1];
      replies_due.push_back(r);
   endfunction

   function automatic void push_reply_text(string s);
      for (int k = 0; k < s.len(); k++)
         push_reply_byte(s[k], k == s.len() - 1);
   endfunction

   function automatic void predict_request(logic [7:0] b, logic s1, logic s2);
      logic [1:0] mask;
      if (b != slcgb_pkg::CHAR_LF && b != slcgb_pkg::CHAR_CR) begin
         if (line_len < LINE_LIMIT - 1) begin
            if (b == slcgb_pkg::CHAR_NUL) begin
               nul_seen = 1'b1;
            end else if (!nul_seen) begin
               if (text_len < 3)
                  head[text_len] = b;
               text_len++;
            end
            line_len++;
         end else begin
            // full line: byte is dropped and the line starts over
            line_len = 0;
            text_len = 0;
            nul_seen = 1'b0;
         end
         return;
      end
      if (text_len == 1 && head[0] == slcgb_pkg::CHAR_R) begin
         pin_levels = 2'b00;
         push_reply_text("Outputs Reset\n");
      end else if (text_len == 1 && head[0] == slcgb_pkg::CHAR_D) begin
         push_reply_byte(slcgb_pkg::CHAR_ZERO | {6'd0, s1, s2}, 1'b0);
         push_reply_byte(slcgb_pkg::CHAR_LF, 1'b1);
      end else if (text_len == 3 && head[0] == slcgb_pkg::CHAR_S) begin
         if ((head[1] == slcgb_pkg::CHAR_ZERO || head[1] == slcgb_pkg::CHAR_ONE) &&
             (head[2] == slcgb_pkg::CHAR_ZERO || head[2] == slcgb_pkg::CHAR_ONE)) begin
            mask = (head[1] == slcgb_pkg::CHAR_ONE) ? 2'b10 : 2'b01;
            if (head[2] == slcgb_pkg::CHAR_ONE)
               pin_levels = pin_levels | mask;
            else
               pin_levels = pin_levels & ~mask;
            push_reply_text("Output Set\n");
         end else begin
            push_reply_text("Invalid sXY Format\n");
         end
      end else begin
         push_reply_text("Unknown Command\n");
      end
      line_len = 0;
      text_len = 0;
      nul_seen = 1'b0;
   endfunction

   task automatic send_request(logic [7:0] b, logic s1, logic s2);
      while (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= b;
      req_sensor_one <= s1;
      req_sensor_two <= s2;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_request(b, s1, s2);
      requests_sent++;
   endtask

   task automatic send_line(string s, logic [7:0] term, logic s1, logic s2);
      for (int k = 0; k < s.len(); k++)
         send_request(s[k], coin(), coin());
      send_request(term, s1, s2);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_commands();
      send_line("r", slcgb_pkg::CHAR_LF, 1'b0, 1'b0);
      send_line("d", slcgb_pkg::CHAR_CR, 1'b0, 1'b0);
      send_line("d", slcgb_pkg::CHAR_LF, 1'b0, 1'b1);
      send_line("d", slcgb_pkg::CHAR_LF, 1'b1, 1'b0);
      send_line("d", slcgb_pkg::CHAR_CR, 1'b1, 1'b1);
      send_line("s11", slcgb_pkg::CHAR_LF, 1'b0, 1'b1);
      send_line("s01", slcgb_pkg::CHAR_CR, 1'b1, 1'b0);
      send_line("s00", slcgb_pkg::CHAR_LF, 1'b1, 1'b1);
      send_line("s10", slcgb_pkg::CHAR_LF, 1'b0, 1'b0);
   endtask

   task automatic test_bad_forms();
      send_line("s2Z", slcgb_pkg::CHAR_LF, 1'b0, 1'b0);
      send_line("s0", slcgb_pkg::CHAR_CR, 1'b1, 1'b1);
      send_line("", slcgb_pkg::CHAR_LF, 1'b0, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(slcgb_pkg::CHAR_CR, 1'b1, 1'b0);
   endtask

   task automatic test_zero_byte();
      // zero byte first leaves an empty text
      send_request(slcgb_pkg::CHAR_NUL, 1'b0, 1'b0);
      send_line("r", slcgb_pkg::CHAR_LF, 1'b0, 1'b0);
      send_line("s11", slcgb_pkg::CHAR_LF, 1'b1, 1'b1);
      // text ends at the zero byte, so this is a plain "r"
      send_request(slcgb_pkg::CHAR_R, 1'b0, 1'b1);
      send_request(slcgb_pkg::CHAR_NUL, 1'b1, 1'b0);
      send_line("zz", slcgb_pkg::CHAR_CR, 1'b0, 1'b0);
   endtask

   task automatic test_line_full();
      repeat (LINE_LIMIT - 1)
         send_request("a", coin(), coin());
      send_request(slcgb_pkg::CHAR_R, 1'b0, 1'b0);
      send_line("d", slcgb_pkg::CHAR_LF, 1'b1, 1'b0);
      repeat (LINE_LIMIT - 1)
         send_request("b", coin(), coin());
      send_request(slcgb_pkg::CHAR_CR, 1'b0, 1'b1);
   endtask

   task automatic test_drain_pause();
      send_line("s11", slcgb_pkg::CHAR_LF, 1'b0, 1'b0);
      wait_drained();
      send_line("d", slcgb_pkg::CHAR_CR, 1'b1, 1'b1);
      send_line("r", slcgb_pkg::CHAR_LF, 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int         start;
      int         pick;
      int         n;
      logic [7:0] x;
      logic [7:0] y;
      start = requests_sent;
      while (requests_sent - start < RANDOM_ITEMS) begin
         calm = (requests_sent - start >= 60) && (requests_sent - start < 160);
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            case ($urandom_range(0, 2))
               0: send_request(slcgb_pkg::CHAR_R, coin(), coin());
               1: send_request(slcgb_pkg::CHAR_D, coin(), coin());
               default: begin
                  x = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                      : slcgb_pkg::CHAR_ZERO | 8'($urandom_range(0, 1));
                  y = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                      : slcgb_pkg::CHAR_ZERO | 8'($urandom_range(0, 1));
                  send_request(slcgb_pkg::CHAR_S, coin(), coin());
                  send_request(x, coin(), coin());
                  send_request(y, coin(), coin());
               end
            endcase
            if ($urandom_range(0, 9) == 0) begin
               send_request(slcgb_pkg::CHAR_NUL, coin(), coin());
               n = $urandom_range(0, 3);
               repeat (n)
                  send_request(8'($urandom_range(8'h20, 8'h7e)), coin(), coin());
            end else if ($urandom_range(0, 9) == 0) begin
               send_request(8'($urandom_range(8'h20, 8'h7e)), coin(), coin());
            end
         end else if (pick < 99) begin
            n = $urandom_range(0, 6);
            repeat (n)
               send_request(8'($urandom_range(0, 255)), coin(), coin());
         end else begin
            // runs up to the line limit, often past it
            n = $urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 3);
            repeat (n)
               send_request(8'($urandom_range(8'h20, 8'h7e)), coin(), coin());
         end
         send_request(coin() ? slcgb_pkg::CHAR_LF : slcgb_pkg::CHAR_CR, coin(), coin());
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      if (calm)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < 15);
   end

   always @(posedge clock) begin : check_replies
      reply_byte_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $error("unexpected reply byte: tx_byte %h", rsp_tx_byte);
            failures++;
         end else begin
            due = replies_due.pop_front();
            if (rsp_tx_byte !== due.tx_byte) begin
               $error("tx_byte: expected %h, actual %h", due.tx_byte, rsp_tx_byte);
               failures++;
            end
            if (rsp_reply_last !== due.last) begin
               $error("reply_last: expected %b, actual %b", due.last, rsp_reply_last);
               failures++;
            end
            if (rsp_drive_zero !== due.pin_zero) begin
               $error("drive_zero: expected %b, actual %b", due.pin_zero, rsp_drive_zero);
               failures++;
            end
            if (rsp_drive_one !== due.pin_one) begin
               $error("drive_one: expected %b, actual %b", due.pin_one, rsp_drive_one);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL serial_line_command_gpio_bridge");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_commands();
      test_bad_forms();
      test_zero_byte();
      test_line_full();
      test_drain_pause();
      test_random_traffic();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && replies_due.size() == 0)
         $display("PASS serial_line_command_gpio_bridge");
      else
         $display("FAIL serial_line_command_gpio_bridge");
      $finish;
   end

endmodule

/* sim.f */
rtl/slcgb_pkg.sv
rtl/slcgb_front.sv
rtl/slcgb_queue.sv
rtl/slcgb_back.sv
rtl/serial_line_command_gpio_bridge.sv
dv/tb_top.sv
